### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behaviour.
// No dependencies; take in by include at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/spa_pkg.sv
// Types, sizes and codes for the sparse polynomial adder.
// No dependencies; used by the controller, datapath and top level.
package spa_pkg;

   localparam int MAX_TERMS  = 32;
   localparam int COEF_BITS  = 32;
   localparam int EXP_BITS   = 16;
   localparam int CNT_BITS   = $clog2(MAX_TERMS + 1);
   localparam int ADDR_BITS  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int STORE_BITS = COEF_BITS + EXP_BITS;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_RUN    = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] term_coefficient;
      logic [15:0]        term_exponent;
   } spa_req_type;

   typedef struct packed {
      logic signed [31:0] sum_coefficient;
      logic [15:0]        sum_exponent;
      logic               last_term;
      logic               result_empty;
   } spa_rsp_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] coef;
      logic [EXP_BITS-1:0]  expo;
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MERGE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start;
      logic step;
      logic finish;
   } spa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic a_act;
      logic b_act;
      logic pend_valid;
      logic out_free;
   } spa_sts_type;

endpackage

### hw/rtl/spa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/spa_ctrl.sv
// Sequencing state machine for the sparse polynomial adder.
// Depends on spa_pkg; drives commands into spa_datapath.
module spa_ctrl
   import spa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_op,
   output logic        req_stall,
   input  spa_sts_type sts,
   output spa_cmd_type cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_LOAD_A: cmd.load_a = 1'b1;
                  OP_LOAD_B: cmd.load_b = 1'b1;
                  OP_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         // wait for store read data
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!sts.a_act && !sts.b_act) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/spa_datapath.sv
// Term stores, merge compare and add, one-term lookahead and output register.
// Depends on spa_pkg and spa_ram; commanded by spa_ctrl.
module spa_datapath
   import spa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  spa_req_type req_data,
   input  spa_cmd_type cmd,
   output spa_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output spa_rsp_type rsp_data
);

   logic [CNT_BITS-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_BITS-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic                pend_valid_ff, pend_valid_in;
   term_type            pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spa_rsp_type         rsp_data_ff, rsp_data_in;

   term_type            new_term, term_a, term_b, cand;
   logic                wr_a, wr_b, a_act, b_act, out_free;
   logic                adv_a, adv_b, cand_valid;
   logic [COEF_BITS-1:0] coef_sum;

   // Incoming term, sign-extended into the store width
   assign new_term.coef = COEF_BITS'(req_data.term_coefficient);
   assign new_term.expo = EXP_BITS'(req_data.term_exponent);

   assign wr_a = cmd.load_a && (cnt_a_ff < CNT_BITS'(MAX_TERMS));
   assign wr_b = cmd.load_b && (cnt_b_ff < CNT_BITS'(MAX_TERMS));

   spa_ram #(.WIDTH(STORE_BITS), .DEPTH(MAX_TERMS)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[ADDR_BITS-1:0]),
      .wr_data (new_term),
      .rd_addr (ia_ff[ADDR_BITS-1:0]),
      .rd_data (term_a)
   );

   spa_ram #(.WIDTH(STORE_BITS), .DEPTH(MAX_TERMS)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[ADDR_BITS-1:0]),
      .wr_data (new_term),
      .rd_addr (ib_ff[ADDR_BITS-1:0]),
      .rd_data (term_b)
   );

   assign a_act    = ia_ff < cnt_a_ff;
   assign b_act    = ib_ff < cnt_b_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign coef_sum = term_a.coef + term_b.coef;

   assign sts.a_act      = a_act;
   assign sts.b_act      = b_act;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   // Compare heads and pick the next candidate term
   always_comb begin
      adv_a      = 1'b0;
      adv_b      = 1'b0;
      cand_valid = 1'b0;
      cand       = term_a;
      if (a_act && b_act) begin
         if (term_a.expo > term_b.expo) begin
            adv_a      = 1'b1;
            cand_valid = 1'b1;
         end else if (term_a.expo < term_b.expo) begin
            adv_b      = 1'b1;
            cand_valid = 1'b1;
            cand       = term_b;
         end else begin
            adv_a      = 1'b1;
            adv_b      = 1'b1;
            cand.coef  = coef_sum;
            cand_valid = (coef_sum != '0);
         end
      end else if (a_act) begin
         adv_a      = 1'b1;
         cand_valid = 1'b1;
      end else if (b_act) begin
         adv_b      = 1'b1;
         cand_valid = 1'b1;
         cand       = term_b;
      end
   end

   // Advance indices, hold the lookahead term, load the output register
   always_comb begin
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (wr_a) begin
         cnt_a_in = cnt_a_ff + CNT_BITS'(1);
      end
      if (wr_b) begin
         cnt_b_in = cnt_b_ff + CNT_BITS'(1);
      end
      if (cmd.start) begin
         ia_in = '0;
         ib_in = '0;
      end
      if (cmd.step) begin
         ia_in = ia_ff + CNT_BITS'(adv_a);
         ib_in = ib_ff + CNT_BITS'(adv_b);
         if (cand_valid) begin
            pend_in       = cand;
            pend_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.sum_coefficient = 32'(pend_ff.coef);
               rsp_data_in.sum_exponent    = 16'(pend_ff.expo);
               rsp_data_in.last_term       = 1'b0;
               rsp_data_in.result_empty    = 1'b0;
            end
         end
      end
      if (cmd.finish) begin
         cnt_a_in      = '0;
         cnt_b_in      = '0;
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_data_in.last_term = 1'b1;
         if (pend_valid_ff) begin
            rsp_data_in.sum_coefficient = 32'(pend_ff.coef);
            rsp_data_in.sum_exponent    = 16'(pend_ff.expo);
            rsp_data_in.result_empty    = 1'b0;
         end else begin
            rsp_data_in.sum_coefficient = '0;
            rsp_data_in.sum_exponent    = '0;
            rsp_data_in.result_empty    = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/sparse_polynomial_adder.sv
// Sparse polynomial adder: two term stores merged by exponent.
// Depends on spa_pkg, spa_ctrl, spa_datapath, spa_ram and assert_macros.svh.
//
// Request channel (req_valid/req_stall/req_data): operation 0 appends one
// term to store A, 1 to store B, 2 runs the merge, 3 is ignored. Appends to
// a full store (32 terms) are dropped. A load or an ignored code does not
// stall, and the next request may follow in the next cycle.
// A run stalls the request channel while it works. Each merge step is a read
// of both stores' head terms from RAM followed by a compare and add, with at
// most count A + count B steps; closing the run is a read followed by the
// final transfer into the output register. Results leave one step behind
// the merge because a term is held back until it is known whether it is the
// last one.
// Response channel (rsp_valid/rsp_stall/rsp_data): terms in descending
// exponent order, last_term set on the final one; a run with no surviving
// terms gives one result with result_empty and last_term set. A stalled
// result holds in the output register and the merge waits behind it; loads
// are still taken while a result waits.
// Reset clears both term counts, the state machine and the output valid.
`include "assert_macros.svh"

module sparse_polynomial_adder
   import spa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  spa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output spa_rsp_type rsp_data
);

   spa_cmd_type cmd;
   spa_sts_type sts;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An empty result always closes its run
   `ASSERT_IMPLIES(a_empty_is_last, clock, reset, rsp_valid && rsp_data.result_empty, rsp_data.last_term, "empty result without last_term")

   // An empty result carries zero fields
   `ASSERT_IMPLIES(a_empty_zero, clock, reset, rsp_valid && rsp_data.result_empty, (rsp_data.sum_coefficient == '0) && (rsp_data.sum_exponent == '0), "empty result with nonzero fields")

   // A run transfer makes the block busy in the next cycle
   `ASSERT_NEXT(a_run_busy, clock, reset, req_valid && !req_stall && (req_data.operation == OP_RUN), req_stall, "run accepted but request channel not stalled")

   // Never step and close a run in the same cycle
   `ASSERT_IMPLIES(a_cmd_excl, clock, reset, cmd.step, !cmd.finish && !cmd.start, "conflicting merge commands")

endmodule

### verif/sparse_polynomial_adder_tb.sv
// Self-checking testbench for sparse_polynomial_adder: loads random and corner-case term
// lists, runs merges and checks every result term against an in-bench merge model.
// Depends on spa_pkg and the sparse_polynomial_adder RTL.
`timescale 1ns / 1ps

module sparse_polynomial_adder_tb;
   import spa_pkg::*;

   localparam logic [1:0]  OP_IGNORED  = 2'd3;
   localparam logic [31:0] COEF_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] COEF_MIN    = 32'h8000_0000;
   localparam logic [15:0] EXP_TOP     = 16'hFFFF;
   localparam int          ITEM_TARGET = 200;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          TAIL_CYCLES = 20;

   typedef struct {
      spa_req_type req;
      bit          wait_drain;
   } queued_req_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   spa_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   spa_rsp_type rsp_data;

   queued_req_type req_backlog[$];
   spa_rsp_type    sum_terms_due[$];
   term_type       poly_a[MAX_TERMS];
   term_type       poly_b[MAX_TERMS];
   int             count_a = 0;
   int             count_b = 0;

   bit          hold_for_drain = 1'b0;
   int          counted_items = 0;
   int          backlog_total = 0;
   int          items_in = 0;
   int          merges_run = 0;
   int          terms_checked = 0;
   int          empty_sums = 0;
   int          errors = 0;
   int          quiet_cycles = 0;
   int          send_gap_pct;
   int          recv_gap_pct;
   logic        req_fire = 1'b0;
   spa_rsp_type want;

   sparse_polynomial_adder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle mix by progress: light sender gaps with heavy receiver stalls, then the
   // reverse, then full rate on both sides
   assign send_gap_pct = (items_in < backlog_total / 3) ? 15 :
                         (items_in < 2 * backlog_total / 3) ? 72 : 0;
   assign recv_gap_pct = (items_in < backlog_total / 3) ? 72 :
                         (items_in < 2 * backlog_total / 3) ? 15 : 0;

   // Merge model: append terms, or merge both lists by exponent and clear them
   task automatic update_sum_model(spa_req_type r);
      term_type             t;
      spa_rsp_type          merged[$];
      spa_rsp_type          tail;
      logic [COEF_BITS-1:0] s;
      longint               sx;
      int                   ia;
      int                   ib;
      sx = r.term_coefficient;
      t.coef = sx[COEF_BITS-1:0];
      t.expo = r.term_exponent[EXP_BITS-1:0];
      ia = 0;
      ib = 0;
      case (r.operation)
         OP_LOAD_A: begin
            if (count_a < MAX_TERMS) begin
               poly_a[count_a] = t;
               count_a++;
            end
         end
         OP_LOAD_B: begin
            if (count_b < MAX_TERMS) begin
               poly_b[count_b] = t;
               count_b++;
            end
         end
         OP_RUN: begin
            while (ia < count_a || ib < count_b) begin
               if (ib >= count_b || (ia < count_a && poly_a[ia].expo > poly_b[ib].expo)) begin
                  merged.push_back('{sum_coefficient: 32'(poly_a[ia].coef),
                                     sum_exponent: 16'(poly_a[ia].expo),
                                     last_term: 1'b0, result_empty: 1'b0});
                  ia++;
               end else if (ia >= count_a || poly_a[ia].expo < poly_b[ib].expo) begin
                  merged.push_back('{sum_coefficient: 32'(poly_b[ib].coef),
                                     sum_exponent: 16'(poly_b[ib].expo),
                                     last_term: 1'b0, result_empty: 1'b0});
                  ib++;
               end else begin
                  // equal exponents: add with wrap, drop a zero sum
                  s = poly_a[ia].coef + poly_b[ib].coef;
                  if (s != '0)
                     merged.push_back('{sum_coefficient: 32'(s),
                                        sum_exponent: 16'(poly_a[ia].expo),
                                        last_term: 1'b0, result_empty: 1'b0});
                  ia++;
                  ib++;
               end
            end
            if (merged.size() == 0) begin
               merged.push_back('{sum_coefficient: '0, sum_exponent: '0,
                                  last_term: 1'b1, result_empty: 1'b1});
            end else begin
               tail = merged.pop_back();
               tail.last_term = 1'b1;
               merged.push_back(tail);
            end
            foreach (merged[i])
               sum_terms_due.push_back(merged[i]);
            count_a = 0;
            count_b = 0;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected 0x%h, got 0x%h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   task automatic queue_req(logic [1:0] op, logic [31:0] coef, logic [15:0] expo);
      queued_req_type q;
      q.req.operation        = op;
      q.req.term_coefficient = coef;
      q.req.term_exponent    = expo;
      q.wait_drain           = hold_for_drain;
      hold_for_drain         = 1'b0;
      req_backlog.push_back(q);
      if (op != OP_IGNORED)
         counted_items++;
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(11))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return 32'hFFFF_FFFF;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Well-formed pair of descending lists over one exponent walk, so that
   // shared exponents are common; some shared terms cancel outright
   task automatic queue_merge_case(int steps);
      logic [31:0] ca[$];
      logic [31:0] cb[$];
      logic [15:0] ea[$];
      logic [15:0] eb[$];
      logic [31:0] c;
      int          expo;
      int          pick;
      int          s;
      int          ia;
      int          ib;
      expo = ($urandom_range(7) == 0) ? 65535 : $urandom_range(65535);
      for (s = 0; s < steps && expo >= 0; s++) begin
         pick = $urandom_range(2);
         c = pick_coef();
         if (pick != 1 && ea.size() < MAX_TERMS) begin
            ea.push_back(16'(expo));
            ca.push_back(c);
         end
         if (pick != 0 && eb.size() < MAX_TERMS) begin
            eb.push_back(16'(expo));
            cb.push_back((pick == 2 && $urandom_range(2) == 0) ? -c : pick_coef());
         end
         expo -= $urandom_range(1, 3);
      end
      // interleave the two load streams at random
      ia = 0;
      ib = 0;
      while (ia < ea.size() || ib < eb.size()) begin
         if (ib >= eb.size() || (ia < ea.size() && $urandom_range(1) == 1)) begin
            queue_req(OP_LOAD_A, ca[ia], ea[ia]);
            ia++;
         end else begin
            queue_req(OP_LOAD_B, cb[ib], eb[ib]);
            ib++;
         end
         if ($urandom_range(29) == 0)
            queue_req(OP_IGNORED, $urandom(), 16'($urandom()));
      end
      queue_req(OP_RUN, $urandom(), 16'($urandom()));
   endtask

   // Overfill one store past capacity, add a term to the other, then merge
   task automatic queue_overflow_case();
      logic [1:0] side;
      int         expo;
      int         n;
      int         total;
      side  = ($urandom_range(1) == 1) ? OP_LOAD_B : OP_LOAD_A;
      expo  = 65535;
      total = MAX_TERMS + $urandom_range(1, 4);
      for (n = 0; n < total; n++) begin
         queue_req(side, pick_coef(), 16'(expo));
         expo -= $urandom_range(1, 100);
      end
      queue_req((side == OP_LOAD_A) ? OP_LOAD_B : OP_LOAD_A, pick_coef(), 16'($urandom()));
      queue_req(OP_RUN, $urandom(), 16'($urandom()));
   endtask

   // Unsorted, random-operation noise, sometimes closed by a merge
   task automatic queue_noise_case();
      int n;
      int k;
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++)
         queue_req(2'($urandom_range(3)), pick_coef(), 16'($urandom()));
      if ($urandom_range(1) == 1)
         queue_req(OP_RUN, $urandom(), 16'($urandom()));
   endtask

   // Driver: advance on a transfer, hold a stalled one, else draw a gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_fire)
            req_backlog.delete(0);
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
         if (!req_valid || req_fire) begin
            if (req_backlog.size() == 0 ||
                (req_backlog[0].wait_drain && sum_terms_due.size() != 0) ||
                $urandom_range(99) < send_gap_pct) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= req_backlog[0].req;
            end
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            update_sum_model(req_data);
            items_in++;
            if (req_data.operation == OP_RUN)
               merges_run++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (sum_terms_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, got 0x%h", $time, rsp_data);
               errors++;
            end else begin
               want = sum_terms_due.pop_front();
               check_field("sum_coefficient", want.sum_coefficient, rsp_data.sum_coefficient);
               check_field("sum_exponent", 32'(want.sum_exponent), 32'(rsp_data.sum_exponent));
               check_field("last_term", 32'(want.last_term), 32'(rsp_data.last_term));
               check_field("result_empty", 32'(want.result_empty), 32'(rsp_data.result_empty));
               terms_checked++;
               if (want.result_empty)
                  empty_sums++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("[sparse_polynomial_adder] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // merge of two empty stores gives the empty marker
      queue_req(OP_RUN, COEF_MAX, EXP_TOP);
      queue_req(OP_IGNORED, 32'hFFFF_FFFF, EXP_TOP);
      // top exponent sum wraps, cancelling middle term, lowest exponent
      queue_req(OP_LOAD_A, COEF_MAX, EXP_TOP);
      queue_req(OP_LOAD_B, 32'd1, EXP_TOP);
      queue_req(OP_LOAD_A, 32'd5, 16'd100);
      queue_req(OP_LOAD_B, -32'd5, 16'd100);
      queue_req(OP_LOAD_B, COEF_MIN, 16'd7);
      queue_req(OP_LOAD_A, 32'hFFFF_FFFF, 16'd0);
      queue_req(OP_RUN, '0, '0);
      // full cancellation gives the empty marker
      queue_req(OP_LOAD_A, 32'd42, 16'd9);
      queue_req(OP_LOAD_B, -32'd42, 16'd9);
      queue_req(OP_RUN, '0, '0);
      // one store only, zero coefficient passes through untouched
      queue_req(OP_LOAD_B, COEF_MIN, EXP_TOP);
      queue_req(OP_LOAD_B, '0, 16'd3);
      queue_req(OP_RUN, 32'h5555_5555, 16'hAAAA);
      // unsorted store A still merges by compare and advance
      queue_req(OP_LOAD_A, 32'd1, 16'd3);
      queue_req(OP_LOAD_A, 32'd2, 16'd10);
      queue_req(OP_LOAD_B, 32'd3, 16'd5);
      queue_req(OP_RUN, '0, '0);
      // ignored code between a load and its merge
      queue_req(OP_LOAD_A, 32'd7, 16'd1);
      queue_req(OP_IGNORED, '0, '0);
      queue_req(OP_RUN, '0, '0);

      // hold the first random load until every result so far has arrived
      hold_for_drain = 1'b1;
      queue_overflow_case();
      while (counted_items < ITEM_TARGET) begin
         if ($urandom_range(9) == 0)
            hold_for_drain = 1'b1;
         case ($urandom_range(99)) inside
            [0:74]:  queue_merge_case(($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                               : $urandom_range(0, 8));
            [75:78]: queue_overflow_case();
            default: queue_noise_case();
         endcase
      end
      backlog_total = req_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || sum_terms_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request transfers with %0d merges, including store overflow,",
               items_in, merges_run);
      $display("cancelling and unsorted terms; %0d result terms checked, %0d empty sums.",
               terms_checked, empty_sums);
      if (errors == 0)
         $display("[sparse_polynomial_adder] OK");
      else
         $display("[sparse_polynomial_adder] ERROR");
      $finish;
   end

endmodule
